// ===== hdl/dda_line_rasterizer_macros.svh =====
// Assertion macros shared by the line rasterizer modules.
`ifndef DDA_LINE_RASTERIZER_MACROS_SVH
`define DDA_LINE_RASTERIZER_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DLR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DLR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/dlr_pkg.sv =====
`timescale 1ns / 1ps

package dlr_pkg;

   // Default geometry: pixel coordinate width and fraction bits of the accumulators.
   localparam int COORD_BITS = 10;
   localparam int FRAC_BITS  = 16;

   // Operation codes carried on the request func field.
   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_ADVANCE = 1'b1;

   // Status that the divider reports back to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ===== hdl/dlr_divider.sv =====
`timescale 1ns / 1ps

`include "dda_line_rasterizer_macros.svh"

// Restoring divider that forms floor((dividend << FRAC_BITS) / divisor).
// The dividend never exceeds the divisor, so the quotient has FRAC_BITS+1 bits
// and the partial remainder stays below twice the divisor.
// One quotient bit is produced per cycle.
module dlr_divider #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [COORD_BITS-1:0]     dividend,
   input  logic [COORD_BITS-1:0]     divisor,
   output dlr_pkg::div_status_type   status,
   output logic [FRAC_BITS:0]        quotient
);

   localparam int CNT_BITS = $clog2(FRAC_BITS + 1);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_BITS-1:0]   cnt_ff;
   logic [COORD_BITS:0]   rem_ff;
   logic [COORD_BITS-1:0] divisor_ff;
   logic [FRAC_BITS:0]    quot_ff;

   logic                  trial_ge;
   logic [COORD_BITS:0]   rem_sub;
   logic [COORD_BITS:0]   rem_in;

   // Trial subtraction of the divisor from the partial remainder.
   always_comb begin
      trial_ge = rem_ff >= {1'b0, divisor_ff};
      rem_sub  = trial_ge ? (rem_ff - {1'b0, divisor_ff}) : rem_ff;
      rem_in   = {rem_sub[COORD_BITS-1:0], 1'b0};
   end

   // Control: a start loads the operands, then one bit per cycle until the count runs out.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_BITS'(FRAC_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_BITS'(1);
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: remainder, divisor and quotient shift register.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff     <= {1'b0, dividend};
         divisor_ff <= divisor;
         quot_ff    <= '0;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[FRAC_BITS-1:0], trial_ge};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quot_ff;

   `DLR_ASSERT_NOW(a_div_no_restart, start, !busy_ff, "divider started while busy")
   `DLR_ASSERT_NOW(a_div_done_idle, done_ff, !busy_ff, "divider done while still busy")
   `DLR_ASSERT_NOW(a_div_quot_range, done_ff,
      !quot_ff[FRAC_BITS] || (quot_ff[FRAC_BITS-1:0] == '0),
      "increment magnitude above one")

endmodule

// ===== hdl/dda_line_rasterizer.sv =====
`timescale 1ns / 1ps

`include "dda_line_rasterizer_macros.svh"

// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  func, x_start, y_start, x_end, y_end
// rsp_      out        rsp_valid / rsp_ready  point_x, point_y, last
//
// An advance's point appears in the output register in the cycle after it is accepted.
// A load of a zero-length line starts no division; any other load runs the shared
// bit-serial divider, which forms the x and then the y increment.
// req_ready is low while the divider runs and while an unaccepted point would be overwritten.
// Synchronous active-high reset clears the line; a following advance gives no point.
module dda_line_rasterizer #(
   parameter int COORD_BITS = dlr_pkg::COORD_BITS,
   parameter int FRAC_BITS  = dlr_pkg::FRAC_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [COORD_BITS-1:0] req_x_start,
   input  logic [COORD_BITS-1:0] req_y_start,
   input  logic [COORD_BITS-1:0] req_x_end,
   input  logic [COORD_BITS-1:0] req_y_end,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [COORD_BITS-1:0] rsp_point_x,
   output logic [COORD_BITS-1:0] rsp_point_y,
   output logic                  rsp_last
);

   localparam int ACC_BITS  = COORD_BITS + FRAC_BITS + 1;
   localparam int STEP_BITS = FRAC_BITS + 2;
   localparam int CNT_BITS  = COORD_BITS + 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_X,
      ST_DIV_Y
   } state_type;

   state_type             state_ff, state_in;
   logic [ACC_BITS-1:0]   x_accum_ff, x_accum_in;
   logic [ACC_BITS-1:0]   y_accum_ff, y_accum_in;
   logic [STEP_BITS-1:0]  x_step_ff, x_step_in;
   logic [STEP_BITS-1:0]  y_step_ff, y_step_in;
   logic [CNT_BITS-1:0]   points_left_ff, points_left_in;
   logic                  line_active_ff, line_active_in;
   logic [COORD_BITS-1:0] steps_ff, steps_in;
   logic [COORD_BITS-1:0] ady_ff, ady_in;
   logic                  x_neg_ff, x_neg_in;
   logic                  y_neg_ff, y_neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] point_x_ff, point_x_in;
   logic [COORD_BITS-1:0] point_y_ff, point_y_in;
   logic                  last_ff, last_in;

   logic                  req_xfer;
   logic [COORD_BITS-1:0] adx;
   logic [COORD_BITS-1:0] ady;
   logic [COORD_BITS-1:0] steps;
   logic                  div_start;
   logic [COORD_BITS-1:0] div_dividend;
   logic [COORD_BITS-1:0] div_divisor;
   logic [FRAC_BITS:0]    div_quot;
   logic [STEP_BITS-1:0]  div_mag;
   logic [STEP_BITS-1:0]  div_step;
   logic                  div_neg;
   logic [ACC_BITS-1:0]   half;
   logic [ACC_BITS-1:0]   x_round;
   logic [ACC_BITS-1:0]   y_round;
   dlr_pkg::div_status_type div_status;

   // Accept a request only when idle and no unaccepted point would be overwritten.
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_xfer  = req_valid && req_ready;

   // Endpoint deltas and the dominant-axis step count for a load.
   always_comb begin
      adx   = (req_x_start >= req_x_end) ? (req_x_start - req_x_end)
                                         : (req_x_end - req_x_start);
      ady   = (req_y_start >= req_y_end) ? (req_y_start - req_y_end)
                                         : (req_y_end - req_y_start);
      steps = (adx > ady) ? adx : ady;
   end

   // The shared divider takes x on a load and y once x is finished.
   always_comb begin
      div_dividend = (state_ff == ST_IDLE) ? adx : ady_ff;
      div_divisor  = (state_ff == ST_IDLE) ? steps : steps_ff;
      div_start    = (req_xfer && (req_func == dlr_pkg::FUNC_LOAD) && (steps != '0)) ||
                     ((state_ff == ST_DIV_X) && div_status.done);
   end

   // Apply the sign of the delta to the divider result.
   always_comb begin
      div_neg  = (state_ff == ST_DIV_X) ? x_neg_ff : y_neg_ff;
      div_mag  = {1'b0, div_quot};
      div_step = div_neg ? (~div_mag + STEP_BITS'(1)) : div_mag;
   end

   // Round to nearest pixel, half up.
   always_comb begin
      half    = ACC_BITS'(1) << (FRAC_BITS - 1);
      x_round = x_accum_ff + half;
      y_round = y_accum_ff + half;
   end

   // Next-state logic for the sequencer, the line state and the output register.
   always_comb begin
      state_in       = state_ff;
      x_accum_in     = x_accum_ff;
      y_accum_in     = y_accum_ff;
      x_step_in      = x_step_ff;
      y_step_in      = y_step_ff;
      points_left_in = points_left_ff;
      line_active_in = line_active_ff;
      steps_in       = steps_ff;
      ady_in         = ady_ff;
      x_neg_in       = x_neg_ff;
      y_neg_in       = y_neg_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      point_x_in     = point_x_ff;
      point_y_in     = point_y_ff;
      last_in        = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_func == dlr_pkg::FUNC_LOAD) begin
                  x_accum_in     = {1'b0, req_x_start, {FRAC_BITS{1'b0}}};
                  y_accum_in     = {1'b0, req_y_start, {FRAC_BITS{1'b0}}};
                  x_step_in      = '0;
                  y_step_in      = '0;
                  points_left_in = {1'b0, steps} + CNT_BITS'(1);
                  line_active_in = 1'b1;
                  steps_in       = steps;
                  ady_in         = ady;
                  x_neg_in       = req_x_end < req_x_start;
                  y_neg_in       = req_y_end < req_y_start;
                  if (steps != '0) begin
                     state_in = ST_DIV_X;
                  end
               end else if (line_active_ff && (points_left_ff != '0)) begin
                  rsp_valid_in   = 1'b1;
                  point_x_in     = x_round[FRAC_BITS +: COORD_BITS];
                  point_y_in     = y_round[FRAC_BITS +: COORD_BITS];
                  last_in        = points_left_ff == CNT_BITS'(1);
                  x_accum_in     = x_accum_ff +
                                   {{(ACC_BITS-STEP_BITS){x_step_ff[STEP_BITS-1]}}, x_step_ff};
                  y_accum_in     = y_accum_ff +
                                   {{(ACC_BITS-STEP_BITS){y_step_ff[STEP_BITS-1]}}, y_step_ff};
                  points_left_in = points_left_ff - CNT_BITS'(1);
                  if (points_left_ff == CNT_BITS'(1)) begin
                     line_active_in = 1'b0;
                  end
               end else begin
                  line_active_in = 1'b0;
               end
            end
         end
         ST_DIV_X: begin
            if (div_status.done) begin
               x_step_in = div_step;
               state_in  = ST_DIV_Y;
            end
         end
         ST_DIV_Y: begin
            if (div_status.done) begin
               y_step_in = div_step;
               state_in  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         x_accum_ff     <= '0;
         y_accum_ff     <= '0;
         x_step_ff      <= '0;
         y_step_ff      <= '0;
         points_left_ff <= '0;
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         x_accum_ff     <= x_accum_in;
         y_accum_ff     <= y_accum_in;
         x_step_ff      <= x_step_in;
         y_step_ff      <= y_step_in;
         points_left_ff <= points_left_in;
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      steps_ff   <= steps_in;
      ady_ff     <= ady_in;
      x_neg_ff   <= x_neg_in;
      y_neg_ff   <= y_neg_in;
      point_x_ff <= point_x_in;
      point_y_ff <= point_y_in;
      last_ff    <= last_in;
   end

   dlr_divider #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (div_quot)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_point_x = point_x_ff;
   assign rsp_point_y = point_y_ff;
   assign rsp_last    = last_ff;

   `DLR_ASSERT_NOW(a_done_in_div, div_status.done,
      (state_ff == ST_DIV_X) || (state_ff == ST_DIV_Y), "divider finished while idle")
   `DLR_ASSERT_NOW(a_active_has_points, line_active_ff, points_left_ff != '0,
      "active line with no points left")
   `DLR_ASSERT_NEXT(a_advance_gives_point,
      req_xfer && (req_func == dlr_pkg::FUNC_ADVANCE) && line_active_ff,
      rsp_valid_ff, "advance on an active line gave no point")
   `DLR_ASSERT_NOW(a_busy_not_ready, div_status.busy, !req_ready,
      "request accepted while the divider runs")

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int COORD_BITS = dlr_pkg::COORD_BITS;
   localparam int FRAC_BITS  = dlr_pkg::FRAC_BITS;
   localparam int ACC_W      = COORD_BITS + FRAC_BITS + 1;
   localparam int INC_W      = FRAC_BITS + 2;
   localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
   // Worst-case load time of the divider plus a small margin.
   localparam int SETTLE     = 2 * (FRAC_BITS + 1) + 3 + 6;
   localparam int HOLD_OFF   = 150;
   localparam int STALL_MAX  = 3000;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  last;
   } pixel_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic                  req_func    = dlr_pkg::FUNC_LOAD;
   logic [COORD_BITS-1:0] req_x_start = '0;
   logic [COORD_BITS-1:0] req_y_start = '0;
   logic [COORD_BITS-1:0] req_x_end   = '0;
   logic [COORD_BITS-1:0] req_y_end   = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic [COORD_BITS-1:0] rsp_point_x;
   logic [COORD_BITS-1:0] rsp_point_y;
   logic                  rsp_last;

   // Shadow copy of the line generator state.
   logic [ACC_W-1:0]      x_acc;
   logic [ACC_W-1:0]      y_acc;
   logic [INC_W-1:0]      x_inc;
   logic [INC_W-1:0]      y_inc;
   logic [COORD_BITS:0]   pts_left;
   logic                  line_on;

   pixel_type             points_due[$];

   int                    send_idle_pct  = 0;
   int                    recv_stall_pct = 0;
   logic                  hold_off_req   = 1'b0;
   logic                  hold_off_done  = 1'b0;
   int                    errors         = 0;
   int                    lines_loaded   = 0;
   int                    points_checked = 0;
   int                    work_items     = 0;
   int                    quiet_cycles   = 0;

   dda_line_rasterizer dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_func    (req_func),
      .req_x_start (req_x_start),
      .req_y_start (req_y_start),
      .req_x_end   (req_x_end),
      .req_y_end   (req_y_end),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_point_x (rsp_point_x),
      .rsp_point_y (rsp_point_y),
      .rsp_last    (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Signed per-point increment along one axis, truncated toward zero.
   function automatic logic [INC_W-1:0] axis_increment(input logic [COORD_BITS-1:0] from,
                                                       input logic [COORD_BITS-1:0] to,
                                                       input logic [COORD_BITS:0] steps);
      logic [COORD_BITS-1:0]           delta;
      logic [COORD_BITS+FRAC_BITS-1:0] mag;
      if (steps == 0) return '0;
      delta = (to >= from) ? to - from : from - to;
      mag   = {delta, {FRAC_BITS{1'b0}}} / steps;
      if (to < from) mag = -mag;
      return mag[INC_W-1:0];
   endfunction

   // Accumulator rounded half up to a pixel coordinate.
   function automatic logic [COORD_BITS-1:0] nearest_pixel(input logic [ACC_W-1:0] acc);
      logic [ACC_W:0] sum;
      sum = (ACC_W+1)'(acc) + ((ACC_W+1)'(1) << (FRAC_BITS - 1));
      return sum[FRAC_BITS +: COORD_BITS];
   endfunction

   function automatic logic [COORD_BITS-1:0] rand_coord();
      return COORD_BITS'($urandom_range(0, COORD_MAX));
   endfunction

   // A coordinate within span of c, clipped to the screen.
   function automatic logic [COORD_BITS-1:0] near_coord(input int c, input int span);
      int lo;
      int hi;
      lo = (c - span < 0) ? 0 : c - span;
      hi = (c + span > COORD_MAX) ? COORD_MAX : c + span;
      return COORD_BITS'($urandom_range(lo, hi));
   endfunction

   // Update the shadow state for one accepted request and queue the point it yields.
   task automatic predict_line_point(input logic func,
                                     input logic [COORD_BITS-1:0] xs, input logic [COORD_BITS-1:0] ys,
                                     input logic [COORD_BITS-1:0] xe, input logic [COORD_BITS-1:0] ye);
      logic [COORD_BITS-1:0] adx;
      logic [COORD_BITS-1:0] ady;
      logic [COORD_BITS:0]   steps;
      pixel_type             p;
      if (func == dlr_pkg::FUNC_LOAD) begin
         adx      = (xe >= xs) ? xe - xs : xs - xe;
         ady      = (ye >= ys) ? ye - ys : ys - ye;
         steps    = (adx > ady) ? {1'b0, adx} : {1'b0, ady};
         x_inc    = axis_increment(xs, xe, steps);
         y_inc    = axis_increment(ys, ye, steps);
         x_acc    = ACC_W'(xs) << FRAC_BITS;
         y_acc    = ACC_W'(ys) << FRAC_BITS;
         pts_left = steps + (COORD_BITS+1)'(1);
         line_on  = 1'b1;
         lines_loaded++;
         work_items++;
      end
      else if (!line_on || pts_left == 0) begin
         line_on = 1'b0;
      end
      else begin
         p.x    = nearest_pixel(x_acc);
         p.y    = nearest_pixel(y_acc);
         p.last = (pts_left == 1);
         points_due.push_back(p);
         x_acc    = x_acc + {{(ACC_W-INC_W){x_inc[INC_W-1]}}, x_inc};
         y_acc    = y_acc + {{(ACC_W-INC_W){y_inc[INC_W-1]}}, y_inc};
         pts_left = pts_left - (COORD_BITS+1)'(1);
         if (pts_left == 0) line_on = 1'b0;
         work_items++;
      end
   endtask

   // Offer one request, with random idle cycles first, and wait for its transfer.
   // Called and returns at a falling edge.
   task automatic send_request(input logic func,
                               input logic [COORD_BITS-1:0] xs, input logic [COORD_BITS-1:0] ys,
                               input logic [COORD_BITS-1:0] xe, input logic [COORD_BITS-1:0] ye);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_func    <= func;
      req_x_start <= xs;
      req_y_start <= ys;
      req_x_end   <= xe;
      req_y_end   <= ye;
      do @(posedge clock); while (!req_ready);
      predict_line_point(func, xs, ys, xe, ye);
      @(negedge clock);
   endtask

   task automatic send_advance();
      send_request(dlr_pkg::FUNC_ADVANCE, rand_coord(), rand_coord(), rand_coord(), rand_coord());
   endtask

   // Stop offering requests until every queued point has come back and the block is quiet.
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (points_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic set_traffic(input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
   endtask

   // Advances with no line loaded must be dropped silently.
   task automatic test_advance_when_idle();
      send_request(dlr_pkg::FUNC_ADVANCE, '1, '1, '1, '1);
      send_request(dlr_pkg::FUNC_ADVANCE, '0, '0, '0, '0);
   endtask

   // A zero-length line yields exactly its start point, flagged last.
   task automatic test_zero_length_lines();
      send_request(dlr_pkg::FUNC_LOAD, '0, '0, '0, '0);
      send_advance();
      send_advance();
      send_request(dlr_pkg::FUNC_LOAD, '1, '1, '1, '1);
      send_advance();
      send_advance();
   endtask

   // Loads that cut lines short, ending with one short line walked past its end.
   task automatic test_restart_mid_line();
      send_request(dlr_pkg::FUNC_LOAD, '0, '0, '1, '1);
      repeat (3) send_advance();
      send_request(dlr_pkg::FUNC_LOAD, '1, '0, '0, '1);
      repeat (2) send_advance();
      send_request(dlr_pkg::FUNC_LOAD, COORD_BITS'(5), COORD_BITS'(9),
                   COORD_BITS'(12), COORD_BITS'(2));
      repeat (9) send_advance();
   endtask

   // Walk one long line past its end so the endpoint must come out exact.
   task automatic test_long_line();
      send_request(dlr_pkg::FUNC_LOAD, '1, '0, COORD_BITS'(512), COORD_BITS'(341));
      repeat (513) send_advance();
   endtask

   // Receiver holds off while advances keep coming, so the block must stall its input.
   task automatic test_output_backpressure();
      hold_off_req = 1'b1;
      send_request(dlr_pkg::FUNC_LOAD, COORD_BITS'(100), COORD_BITS'(200),
                   COORD_BITS'(130), COORD_BITS'(181));
      repeat (31) send_advance();
      pause_until_drained();
   endtask

   // Mostly complete lines with random endpoints, plus broken lines and stray advances.
   task automatic run_random_traffic(input int target);
      int                    first;
      int                    span;
      int                    steps;
      int                    rise;
      int                    n_adv;
      logic [COORD_BITS-1:0] xs;
      logic [COORD_BITS-1:0] ys;
      logic [COORD_BITS-1:0] xe;
      logic [COORD_BITS-1:0] ye;
      first = work_items;
      while (work_items - first < target) begin
         if ($urandom_range(0, 9) == 0) send_advance();
         span = ($urandom_range(0, 15) == 0) ? COORD_MAX : $urandom_range(0, 24);
         if ($urandom_range(0, 24) == 0) begin
            xs = $urandom_range(0, 1) ? '1 : '0;
            ys = $urandom_range(0, 1) ? '1 : '0;
            xe = $urandom_range(0, 1) ? '1 : '0;
            ye = $urandom_range(0, 1) ? '1 : '0;
         end
         else begin
            xs = rand_coord();
            ys = rand_coord();
            xe = near_coord(int'(xs), span);
            ye = near_coord(int'(ys), span);
            if ($urandom_range(0, 19) == 0) begin
               xe = xs;
               ye = ys;
            end
         end
         steps = (xe >= xs) ? int'(xe - xs) : int'(xs - xe);
         rise  = (ye >= ys) ? int'(ye - ys) : int'(ys - ye);
         if (rise > steps) steps = rise;
         send_request(dlr_pkg::FUNC_LOAD, xs, ys, xe, ye);
         if (steps > 48 || $urandom_range(0, 5) == 0)
            n_adv = $urandom_range(0, (steps > 48) ? 48 : steps);
         else
            n_adv = steps + 1 + $urandom_range(0, 2);
         repeat (n_adv) send_advance();
         if ($urandom_range(0, 39) == 0) pause_until_drained();
      end
   endtask

   // Receiver: random stalls, or one long hold-off when asked for.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_off_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
            hold_off_done = 1'b1;
         end
         else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   // Compare each point transfer with the oldest queued prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (points_due.size() == 0) begin
            $display("%0t: unexpected point x=%0d y=%0d last=%0d",
                     $time, rsp_point_x, rsp_point_y, rsp_last);
            errors++;
         end
         else begin
            if (rsp_point_x !== points_due[0].x) begin
               $display("%0t: point_x expected %0d, got %0d", $time, points_due[0].x, rsp_point_x);
               errors++;
            end
            if (rsp_point_y !== points_due[0].y) begin
               $display("%0t: point_y expected %0d, got %0d", $time, points_due[0].y, rsp_point_y);
               errors++;
            end
            if (rsp_last !== points_due[0].last) begin
               $display("%0t: last expected %0d, got %0d", $time, points_due[0].last, rsp_last);
               errors++;
            end
            void'(points_due.pop_front());
            points_checked++;
         end
      end
   end

   // Watchdog: give up when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end
      else if (quiet_cycles >= STALL_MAX) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_MAX);
         $display("[FAIL] regression broken");
         $finish;
      end
      else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      x_acc    = '0;
      y_acc    = '0;
      x_inc    = '0;
      y_inc    = '0;
      pts_left = '0;
      line_on  = 1'b0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      set_traffic(0, 0);
      test_advance_when_idle();
      test_zero_length_lines();
      test_restart_mid_line();
      test_long_line();
      run_random_traffic(105);
      pause_until_drained();

      set_traffic(66, 0);
      run_random_traffic(105);
      pause_until_drained();

      set_traffic(0, 66);
      test_output_backpressure();
      run_random_traffic(105);
      pause_until_drained();

      set_traffic(30, 30);
      run_random_traffic(105);
      pause_until_drained();

      $display("Loaded %0d lines and checked %0d points under four idle and stall mixes,",
               lines_loaded, points_checked);
      $display("including zero-length, long and restarted lines and a long output hold-off.");
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
